/* rtl/e2c_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch to calendar package
// Field widths, calendar constants and the elaboration-time day limit shared
// by the channel interfaces and the converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

   // Word field widths.
   localparam int MILLIS_W = 64;
   localparam int ZONE_W   = 12;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MSEC_W   = 10;
   localparam int DOW_W    = 3;

   // Largest year reported as a date.
   localparam int MAX_YEAR = 9999;

   // Calendar constants.
   localparam int MS_PER_SEC    = 1000;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAYS_PER_WEEK = 7;
   localparam int DAYS_PER_ERA  = 146097;
   localparam int DAYS_PER_4Y   = 1460;
   localparam int DAYS_PER_100Y = 36524;
   localparam int DAYS_PER_YEAR = 365;
   localparam int YEARS_PER_ERA = 400;
   localparam int EPOCH_SHIFT   = 719468;  // days from 0000-03-01 to 1970-01-01
   localparam int EPOCH_WEEKDAY = 4;       // 1970-01-01 was a Thursday

   // Quotient bits retired by the shared divider in one cycle.
   localparam int DIGIT_BITS = 4;

   // Days from 1970-01-01 to January 1st of the given year.
   function automatic longint days_to_jan1(input longint yr);
      longint y;
      longint era;
      longint yoe;
      longint doe;
      y   = yr - 1;
      era = y / 400;
      yoe = y - era * 400;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
      return era * 146097 + doe - 719468;
   endfunction

   // First day count whose year lies beyond MAX_YEAR.
   localparam longint DAYS_LIMIT = days_to_jan1(MAX_YEAR + 1);

endpackage
`default_nettype wire

/* rtl/e2c_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch to calendar request channel
// Valid/ready channel that carries one epoch timestamp word.
// ----------------------------------------------------------------------------
interface e2c_req_if;
   logic                          valid;
   logic                          ready;
   logic [e2c_pkg::MILLIS_W-1:0]  epoch_millis;

   modport source (output valid, output epoch_millis, input ready);
   modport sink   (input valid, input epoch_millis, output ready);
endinterface
`default_nettype wire

/* rtl/e2c_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch to calendar response channel
// Valid/ready channel that carries one broken-down calendar word.
// ----------------------------------------------------------------------------
interface e2c_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [e2c_pkg::YEAR_W-1:0]    year;
   logic [e2c_pkg::MONTH_W-1:0]   month;
   logic [e2c_pkg::DAY_W-1:0]     day;
   logic [e2c_pkg::HOUR_W-1:0]    hour;
   logic [e2c_pkg::MINUTE_W-1:0]  minute;
   logic [e2c_pkg::SECOND_W-1:0]  second;
   logic [e2c_pkg::MSEC_W-1:0]    millisecond;
   logic [e2c_pkg::DOW_W-1:0]     day_of_week;
   logic                          out_of_range;

   modport source (output valid, output year, output month, output day, output hour,
                   output minute, output second, output millisecond,
                   output day_of_week, output out_of_range, input ready);
   modport sink   (input valid, input year, input month, input day, input hour,
                   input minute, input second, input millisecond,
                   input day_of_week, input out_of_range, output ready);
endinterface
`default_nettype wire

/* rtl/epoch_to_calendar.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch to calendar converter
// Breaks Unix epoch milliseconds into Gregorian date, time and weekday fields
// in a configurable time zone, using one shared constant divider.
// ----------------------------------------------------------------------------
// A word is taken when req_ch.ready is high, which is only while the converter
// is idle, so a new word is not taken before the last one is through. After the
// divisions the result moves into the output register once that is free, and the
// converter returns to idle. For a year beyond the maximum year the date walk is
// skipped. All divisions run on a single restoring divider that retires
// four quotient bits per cycle and is used in turn for every division: the
// millisecond split, seconds per day, hours, minutes, weekday, the 400-year
// era and the steps that find year of era, day of year and month. A finished
// result waits in the output register while the next word is already being
// worked on. The zone offset in minutes is written through csr_wr_en and
// csr_wr_data and must only change while no word is in flight.
module epoch_to_calendar (
   input  wire logic                                clock,
   input  wire logic                                reset,
   e2c_req_if.sink                                  req_ch,
   e2c_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_wr_en,
   input  wire logic signed [e2c_pkg::ZONE_W-1:0]   csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSEC,
      ST_DAYS,
      ST_HOUR,
      ST_MIN,
      ST_WEEK,
      ST_ERA,
      ST_Y4,
      ST_Y100,
      ST_YEAR,
      ST_CENT,
      ST_MONTH,
      ST_MDAY,
      ST_DONE
   } state_type;

   // Sequencer state.
   state_type state_ff, state_in;

   // Shared divider.
   logic [63:0] div_num_ff, div_num_in;
   logic [17:0] div_rem_ff, div_rem_in;
   logic [17:0] div_den_ff, div_den_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [63:0] num_step;
   logic [17:0] rem_step;

   // Zone offset register.
   logic signed [e2c_pkg::ZONE_W-1:0] zone_ff, zone_in;

   // Working registers.
   logic [e2c_pkg::MSEC_W-1:0]   msec_ff, msec_in;
   logic [37:0]                  days_ff, days_in;
   logic [e2c_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [e2c_pkg::MINUTE_W-1:0] min_ff, min_in;
   logic [e2c_pkg::SECOND_W-1:0] sec_ff, sec_in;
   logic [e2c_pkg::DOW_W-1:0]    dow_ff, dow_in;
   logic [7:0]                   era_ff, era_in;
   logic [17:0]                  doe_ff, doe_in;
   logic [6:0]                   t4_ff, t4_in;
   logic [8:0]                   yoe_ff, yoe_in;
   logic [8:0]                   doy_ff, doy_in;
   logic [3:0]                   mp_ff, mp_in;
   logic [16:0]                  year_ff, year_in;
   logic [e2c_pkg::MONTH_W-1:0]  mon_ff, mon_in;
   logic [e2c_pkg::DAY_W-1:0]    mday_ff, mday_in;
   logic                         oor_ff, oor_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [e2c_pkg::YEAR_W-1:0]     out_year_ff, out_year_in;
   logic [e2c_pkg::MONTH_W-1:0]    out_month_ff, out_month_in;
   logic [e2c_pkg::DAY_W-1:0]      out_day_ff, out_day_in;
   logic [e2c_pkg::HOUR_W-1:0]     out_hour_ff, out_hour_in;
   logic [e2c_pkg::MINUTE_W-1:0]   out_min_ff, out_min_in;
   logic [e2c_pkg::SECOND_W-1:0]   out_sec_ff, out_sec_in;
   logic [e2c_pkg::MSEC_W-1:0]     out_msec_ff, out_msec_in;
   logic [e2c_pkg::DOW_W-1:0]      out_dow_ff, out_dow_in;
   logic                           out_oor_ff, out_oor_in;

   // Intermediate arithmetic between divider passes.
   logic signed [17:0] zone_sec;
   logic signed [56:0] total_sec;
   logic [55:0]        secs_clamp;
   logic [2:0]         week_rem;
   logic [2:0]         dow_val;
   logic [27:0]        z_val;
   logic [18:0]        yoe_num;
   logic [18:0]        doy_val;
   logic [10:0]        mp_num;
   logic [10:0]        md_num;
   logic [8:0]         mday_val;
   logic [3:0]         mon_val;
   logic [16:0]        year_val;

   // One radix-16 step of the restoring divider: four compare-subtracts.
   always_comb begin : div_step
      logic [18:0] trial;
      trial    = '0;
      num_step = div_num_ff;
      rem_step = div_rem_ff;
      for (int i = 0; i < e2c_pkg::DIGIT_BITS; i++) begin
         trial    = {rem_step, num_step[63]};
         num_step = {num_step[62:0], 1'b0};
         if (trial >= {1'b0, div_den_ff}) begin
            trial       = trial - {1'b0, div_den_ff};
            num_step[0] = 1'b1;
         end
         rem_step = trial[17:0];
      end
   end

   // Whole seconds plus the zone offset, clamped at zero.
   assign zone_sec   = zone_ff * 18'sd60;
   assign total_sec  = $signed({2'b00, div_num_ff[54:0]}) + 57'(zone_sec);
   assign secs_clamp = total_sec[56] ? '0 : total_sec[55:0];

   // Weekday from the day count modulo seven.
   assign week_rem = div_rem_ff[2:0];
   assign dow_val  = (week_rem >= 3'(e2c_pkg::DAYS_PER_WEEK - e2c_pkg::EPOCH_WEEKDAY))
                   ? week_rem - 3'(e2c_pkg::DAYS_PER_WEEK - e2c_pkg::EPOCH_WEEKDAY)
                   : week_rem + 3'(e2c_pkg::EPOCH_WEEKDAY);

   // Day count shifted to start on 0000-03-01.
   assign z_val = {3'b000, days_ff[24:0]} + 28'(e2c_pkg::EPOCH_SHIFT);

   // Day of era with the leap days taken out, ready for the year division.
   assign yoe_num = {1'b0, doe_ff} - 19'(t4_ff) + 19'(div_num_ff[2:0])
                  - 19'(doe_ff == 18'(e2c_pkg::DAYS_PER_ERA - 1));

   // Day of year (March based) and the month numerators.
   assign doy_val = {1'b0, doe_ff}
                  - (19'(yoe_ff) * 19'(e2c_pkg::DAYS_PER_YEAR) + 19'(yoe_ff[8:2])
                     - 19'(div_num_ff[1:0]));
   assign mp_num  = {2'b00, doy_val[8:0]} * 11'd5 + 11'd2;
   assign md_num  = {7'b0000000, div_num_ff[3:0]} * 11'd153 + 11'd2;

   // Final date fields.
   assign mday_val = doy_ff - div_num_ff[8:0] + 9'd1;
   assign mon_val  = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;
   assign year_val = 17'(yoe_ff) + 17'(era_ff) * 17'(e2c_pkg::YEARS_PER_ERA)
                   + 17'(mon_val <= 4'd2);

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      zone_in      = csr_wr_en ? csr_wr_data : zone_ff;
      msec_in      = msec_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      dow_in       = dow_ff;
      era_in       = era_ff;
      doe_in       = doe_ff;
      t4_in        = t4_ff;
      yoe_in       = yoe_ff;
      doy_in       = doy_ff;
      mp_in        = mp_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      mday_in      = mday_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_day_in   = out_day_ff;
      out_hour_in  = out_hour_ff;
      out_min_in   = out_min_ff;
      out_sec_in   = out_sec_ff;
      out_msec_in  = out_msec_ff;
      out_dow_in   = out_dow_ff;
      out_oor_in   = out_oor_ff;

      // The divider steps on its own while digits remain.
      if (div_cnt_ff != '0) begin
         div_num_in = num_step;
         div_rem_in = rem_step;
         div_cnt_in = div_cnt_ff - 5'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            // Accept a word and split milliseconds from seconds.
            if (req_ch.valid) begin
               div_num_in = req_ch.epoch_millis;
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::MS_PER_SEC);
               div_cnt_in = 5'd16;
               state_in   = ST_MSEC;
            end
         end
         ST_MSEC: begin
            if (div_cnt_ff == '0) begin
               msec_in    = div_rem_ff[e2c_pkg::MSEC_W-1:0];
               div_num_in = {secs_clamp, 8'h00};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::SECS_PER_DAY);
               div_cnt_in = 5'd14;
               state_in   = ST_DAYS;
            end
         end
         ST_DAYS: begin
            if (div_cnt_ff == '0) begin
               days_in    = div_num_ff[37:0];
               div_num_in = {3'b000, div_rem_ff[16:0], 44'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::SECS_PER_HOUR);
               div_cnt_in = 5'd5;
               state_in   = ST_HOUR;
            end
         end
         ST_HOUR: begin
            if (div_cnt_ff == '0) begin
               hour_in    = div_num_ff[e2c_pkg::HOUR_W-1:0];
               div_num_in = {div_rem_ff[11:0], 52'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::SECS_PER_MIN);
               div_cnt_in = 5'd3;
               state_in   = ST_MIN;
            end
         end
         ST_MIN: begin
            if (div_cnt_ff == '0) begin
               min_in     = div_num_ff[e2c_pkg::MINUTE_W-1:0];
               sec_in     = div_rem_ff[e2c_pkg::SECOND_W-1:0];
               div_num_in = {2'b00, days_ff, 24'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::DAYS_PER_WEEK);
               div_cnt_in = 5'd10;
               state_in   = ST_WEEK;
            end
         end
         ST_WEEK: begin
            if (div_cnt_ff == '0) begin
               dow_in = dow_val;
               if (days_ff >= 38'(e2c_pkg::DAYS_LIMIT)) begin
                  // Year beyond the maximum: no date walk.
                  year_in  = '0;
                  mon_in   = '0;
                  mday_in  = '0;
                  oor_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  oor_in     = 1'b0;
                  div_num_in = {z_val, 36'h0};
                  div_rem_in = '0;
                  div_den_in = 18'(e2c_pkg::DAYS_PER_ERA);
                  div_cnt_in = 5'd7;
                  state_in   = ST_ERA;
               end
            end
         end
         ST_ERA: begin
            if (div_cnt_ff == '0) begin
               era_in     = div_num_ff[7:0];
               doe_in     = div_rem_ff;
               div_num_in = {2'b00, div_rem_ff, 44'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::DAYS_PER_4Y);
               div_cnt_in = 5'd5;
               state_in   = ST_Y4;
            end
         end
         ST_Y4: begin
            if (div_cnt_ff == '0) begin
               t4_in      = div_num_ff[6:0];
               div_num_in = {2'b00, doe_ff, 44'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::DAYS_PER_100Y);
               div_cnt_in = 5'd5;
               state_in   = ST_Y100;
            end
         end
         ST_Y100: begin
            if (div_cnt_ff == '0) begin
               div_num_in = {1'b0, yoe_num, 44'h0};
               div_rem_in = '0;
               div_den_in = 18'(e2c_pkg::DAYS_PER_YEAR);
               div_cnt_in = 5'd5;
               state_in   = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (div_cnt_ff == '0) begin
               yoe_in     = div_num_ff[8:0];
               div_num_in = {3'b000, div_num_ff[8:0], 52'h0};
               div_rem_in = '0;
               div_den_in = 18'd100;
               div_cnt_in = 5'd3;
               state_in   = ST_CENT;
            end
         end
         ST_CENT: begin
            if (div_cnt_ff == '0) begin
               doy_in     = doy_val[8:0];
               div_num_in = {1'b0, mp_num, 52'h0};
               div_rem_in = '0;
               div_den_in = 18'd153;
               div_cnt_in = 5'd3;
               state_in   = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (div_cnt_ff == '0) begin
               mp_in      = div_num_ff[3:0];
               div_num_in = {1'b0, md_num, 52'h0};
               div_rem_in = '0;
               div_den_in = 18'd5;
               div_cnt_in = 5'd3;
               state_in   = ST_MDAY;
            end
         end
         ST_MDAY: begin
            if (div_cnt_ff == '0) begin
               mday_in  = mday_val[e2c_pkg::DAY_W-1:0];
               mon_in   = mon_val;
               year_in  = year_val;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the word over once the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_year_in  = year_ff[e2c_pkg::YEAR_W-1:0];
               out_month_in = mon_ff;
               out_day_in   = mday_ff;
               out_hour_in  = hour_ff;
               out_min_in   = min_ff;
               out_sec_in   = sec_ff;
               out_msec_in  = msec_ff;
               out_dow_in   = dow_ff;
               out_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         zone_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         zone_ff      <= zone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      msec_ff      <= msec_in;
      days_ff      <= days_in;
      hour_ff      <= hour_in;
      min_ff       <= min_in;
      sec_ff       <= sec_in;
      dow_ff       <= dow_in;
      era_ff       <= era_in;
      doe_ff       <= doe_in;
      t4_ff        <= t4_in;
      yoe_ff       <= yoe_in;
      doy_ff       <= doy_in;
      mp_ff        <= mp_in;
      year_ff      <= year_in;
      mon_ff       <= mon_in;
      mday_ff      <= mday_in;
      oor_ff       <= oor_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_day_ff   <= out_day_in;
      out_hour_ff  <= out_hour_in;
      out_min_ff   <= out_min_in;
      out_sec_ff   <= out_sec_in;
      out_msec_ff  <= out_msec_in;
      out_dow_ff   <= out_dow_in;
      out_oor_ff   <= out_oor_in;
   end

   // Channel outputs.
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.year         = out_year_ff;
   assign rsp_ch.month        = out_month_ff;
   assign rsp_ch.day          = out_day_ff;
   assign rsp_ch.hour         = out_hour_ff;
   assign rsp_ch.minute       = out_min_ff;
   assign rsp_ch.second       = out_sec_ff;
   assign rsp_ch.millisecond  = out_msec_ff;
   assign rsp_ch.day_of_week  = out_dow_ff;
   assign rsp_ch.out_of_range = out_oor_ff;

`ifndef SYNTHESIS
   // The divider is quiet whenever a new word can be taken.
   a_idle_divider: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (div_cnt_ff == '0))
      else $error("divider still running while idle");

   // A taken word makes the converter busy on the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("converter ready right after taking a word");

   // An out-of-range result carries a zero date.
   a_oor_zero_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_of_range) |->
      (rsp_ch.year == '0 && rsp_ch.month == '0 && rsp_ch.day == '0))
      else $error("out-of-range word with a nonzero date");

   // An in-range result carries a legal month, day and weekday.
   a_legal_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_of_range) |->
      (rsp_ch.month >= 4'd1 && rsp_ch.month <= 4'd12 && rsp_ch.day >= 5'd1
       && rsp_ch.day_of_week <= 3'd6))
      else $error("illegal calendar fields in result word");
`endif

endmodule
`default_nettype wire
